>>> rtl/imu_tilt_complementary_filter_assert.svh
// Assertion macros for the IMU tilt filter; empty bodies when SYNTHESIS is defined.
`ifndef IMU_TILT_COMPLEMENTARY_FILTER_ASSERT_SVH
`define IMU_TILT_COMPLEMENTARY_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define ICT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imu tilt filter check failed");
// next-cycle implication, checked out of reset
`define ICT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imu tilt filter check failed");
`else
`define ICT_ASSERT_IMP(lbl, ante, cons)
`define ICT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/ict_pkg.sv
// Shared constants, types and the CORDIC angle table of the IMU tilt filter.
package ict_pkg;

  localparam int CAL_SAMPLES       = 100;
  localparam int CORDIC_ITERATIONS = 16;

  // field widths
  localparam int RAW_W  = 16;
  localparam int ACC_W  = 21;
  localparam int RATE_W = 29;
  localparam int ANG_W  = 25;
  localparam int COEF_W = 16;
  localparam int WGT_W  = 17;
  localparam int DT_W   = 16;
  localparam int BIAS_W = 32;

  // ports
  localparam int IN_DW  = 6 * RAW_W;
  localparam int OUT_DW = 3 * ACC_W + 3 * RATE_W + 2 * ANG_W;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 17;

  // calibration
  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam int SUM_W = RAW_W + $clog2(CAL_SAMPLES) + 1;

  // serial divider
  localparam int DIV_W  = (SUM_W + 17 > 38) ? SUM_W + 17 : 38;
  localparam int DEN_W  = ($clog2(CAL_SAMPLES + 1) > 7) ? $clog2(CAL_SAMPLES + 1) : 7;
  localparam int RATE_DEN  = 82;
  localparam int RATE_HALF = 41;

  // serial multiplier
  localparam int MUL_AW = 33;
  localparam int MUL_BW = 17;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // CORDIC
  localparam int CW      = 32;
  localparam int ZW      = ANG_W;
  localparam int ATAN_IW = 5;

  // scaling and limits
  localparam int ACC_LIM   = 524288;
  localparam int RATE_HI   = 268435455;
  localparam int RATE_LO   = -268435456;
  localparam int ANGLE_LIM = 11796480;
  localparam int Z_TRIM    = 19661;
  localparam int INV_GAIN  = 39797;
  localparam int WGT_ONE   = 65536;
  localparam int PRE_SH    = 8;
  localparam int Q16_SH    = 16;
  localparam int DT_SH     = 24;

  // register reset values
  localparam int ACC_COEF_RST  = 655;
  localparam int GYRO_COEF_RST = 3277;
  localparam int PITCH_W_RST   = 65470;
  localparam int ROLL_W_RST    = 64225;
  localparam int DT_RST        = 8389;

  typedef enum logic [CFG_AW-1:0] {
    CFG_ACC_SMOOTH  = 3'd0,
    CFG_GYRO_SMOOTH = 3'd1,
    CFG_PITCH_W     = 3'd2,
    CFG_ROLL_W      = 3'd3,
    CFG_DT          = 3'd4
  } cfg_reg_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic signed [ZW-1:0] atan_q16(input logic [ATAN_IW-1:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:  v = ZW'(2949120);
      5'd1:  v = ZW'(1740967);
      5'd2:  v = ZW'(919879);
      5'd3:  v = ZW'(466945);
      5'd4:  v = ZW'(234379);
      5'd5:  v = ZW'(117304);
      5'd6:  v = ZW'(58666);
      5'd7:  v = ZW'(29335);
      5'd8:  v = ZW'(14668);
      5'd9:  v = ZW'(7334);
      5'd10: v = ZW'(3667);
      5'd11: v = ZW'(1833);
      5'd12: v = ZW'(917);
      5'd13: v = ZW'(458);
      5'd14: v = ZW'(229);
      5'd15: v = ZW'(115);
      5'd16: v = ZW'(57);
      5'd17: v = ZW'(29);
      5'd18: v = ZW'(14);
      5'd19: v = ZW'(7);
      5'd20: v = ZW'(4);
      5'd21: v = ZW'(2);
      5'd22: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/ict_mul.sv
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier.
module ict_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [ict_pkg::MUL_AW-1:0]   a,
  input  logic        [ict_pkg::MUL_BW-1:0]   b,
  output logic                                done,
  output logic signed [ict_pkg::MUL_PW-1:0]   p
);
  import ict_pkg::*;

  localparam int CNT_MW = $clog2(MUL_BW + 1);

  logic signed [MUL_PW-1:0] a_r, a_nxt;
  logic signed [MUL_PW-1:0] p_r, p_nxt;
  logic        [MUL_BW-1:0] b_r, b_nxt;
  logic        [CNT_MW-1:0] cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;

  // one multiplier bit per cycle
  always_comb begin
    a_nxt    = a_r;
    p_nxt    = p_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = MUL_PW'(a);
      p_nxt    = '0;
      b_nxt    = b;
      cnt_nxt  = CNT_MW'(MUL_BW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) begin
        p_nxt = p_r + a_r;
      end
      a_nxt   = a_r <<< 1;
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r - CNT_MW'(1);
      if (cnt_r == CNT_MW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r <= a_nxt;
    p_r <= p_nxt;
    b_r <= b_nxt;
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

>>> rtl/ict_div.sv
// Bit-serial restoring divider for a non-negative numerator by a small divisor.
module ict_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [ict_pkg::DIV_W-1:0]         num,
  input  logic [ict_pkg::DEN_W-1:0]         den,
  output logic                              done,
  output logic [ict_pkg::DIV_W-1:0]         quo
);
  import ict_pkg::*;

  localparam int CNT_DW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  n_r, n_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [CNT_DW-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DEN_W:0]    trial;

  // one quotient bit per cycle, quotient shifts into the numerator register
  always_comb begin
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, n_r[DIV_W-1]};
    if (start) begin
      n_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_DW'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        n_nxt   = {n_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        n_nxt   = {n_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_DW'(1);
      if (cnt_r == CNT_DW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = n_r;

endmodule

>>> rtl/ict_cordic.sv
// Vectoring CORDIC, one micro-rotation per cycle; raw magnitude and angle in degrees Q16.
module ict_cordic (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [ict_pkg::CW-1:0]    x0,
  input  logic signed [ict_pkg::CW-1:0]    y0,
  output logic                             done,
  output logic signed [ict_pkg::CW-1:0]    xo,
  output logic signed [ict_pkg::ZW-1:0]    zo
);
  import ict_pkg::*;

  logic signed [CW-1:0]  x_r, x_nxt;
  logic signed [CW-1:0]  y_r, y_nxt;
  logic signed [ZW-1:0]  z_r, z_nxt;
  logic [ATAN_IW-1:0]    i_r, i_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic signed [CW-1:0]  xs, ys;
  logic                  y_pos;

  assign xs    = x_r >>> i_r;
  assign ys    = y_r >>> i_r;
  assign y_pos = !y_r[CW-1] && (y_r != '0);

  // rotate toward the x axis, accumulating the table angle
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = x0;
      y_nxt    = y0;
      z_nxt    = '0;
      i_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (y_pos) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_q16(i_r);
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_q16(i_r);
      end
      if (i_r == ATAN_IW'(CORDIC_ITERATIONS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        i_nxt = i_r + ATAN_IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      i_r    <= i_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign done = done_r;
  assign xo   = x_r;
  assign zo   = z_r;

endmodule

>>> rtl/imu_tilt_complementary_filter.sv
// Sequence: a calibration request adds its rate sample to the sums, and the one that completes
//   the bias runs three divides; a process request runs twelve multiplies, three divides,
//   four CORDIC runs and one output step; a zero CORDIC operand skips that run. One request
//   at a time, taken in idle; a result still waiting in the output register holds the last step.
// Reset: rst_n synchronous active low; clears filter state, bias and counters, and sets
//   the configuration registers to their reset values.
`include "imu_tilt_complementary_filter_assert.svh"
module imu_tilt_complementary_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: accel_x_raw, accel_y_raw, accel_z_raw, rate_x_raw, rate_y_raw, rate_z_raw
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ict_pkg::IN_DW-1:0]       in_tdata,
  input  logic                            in_tuser,   // cmd
  // out_tdata: accel_x/y/z_filtered, rate_x/y/z_filtered, pitch_angle, roll_angle
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ict_pkg::OUT_DW-1:0]      out_tdata,
  output logic                            out_tuser,  // bias_updated
  input  logic                            cfg_we,
  input  logic [ict_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [ict_pkg::CFG_DW-1:0]      cfg_wdata
);
  import ict_pkg::*;

  typedef enum logic [20:0] {
    ST_IDLE    = 21'h000001,
    ST_CAL     = 21'h000002,
    ST_BDIV_GO = 21'h000004,
    ST_BDIV_WT = 21'h000008,
    ST_AMUL_GO = 21'h000010,
    ST_AMUL_WT = 21'h000020,
    ST_GDIV_GO = 21'h000040,
    ST_GDIV_WT = 21'h000080,
    ST_GMUL_GO = 21'h000100,
    ST_GMUL_WT = 21'h000200,
    ST_COR1_GO = 21'h000400,
    ST_COR1_WT = 21'h000800,
    ST_MAG_GO  = 21'h001000,
    ST_MAG_WT  = 21'h002000,
    ST_COR2_GO = 21'h004000,
    ST_COR2_WT = 21'h008000,
    ST_DT_GO   = 21'h010000,
    ST_DT_WT   = 21'h020000,
    ST_W_GO    = 21'h040000,
    ST_W_WT    = 21'h080000,
    ST_DONE    = 21'h100000
  } state_t;

  localparam int DW = BIAS_W + 2;   // raw*65536 - bias
  localparam int D5 = DW + 3;       // times five

  // round to nearest, halves away from zero
  function automatic logic signed [MUL_PW-1:0] rnd_shift(input logic signed [MUL_PW-1:0] v,
                                                         input int sh);
    logic [MUL_PW-1:0] mag;
    logic [MUL_PW-1:0] r;
    mag = v[MUL_PW-1] ? MUL_PW'(-v) : MUL_PW'(v);
    r   = (mag + (MUL_PW'(1) << (sh - 1))) >> sh;
    return v[MUL_PW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [MUL_PW-1:0] clamp(input logic signed [MUL_PW-1:0] v,
                                                     input logic signed [MUL_PW-1:0] lo,
                                                     input logic signed [MUL_PW-1:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  state_t state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic       j_r, j_nxt;

  logic signed [RAW_W-1:0]  acc_raw_r [3];
  logic signed [RAW_W-1:0]  acc_raw_nxt [3];
  logic signed [RAW_W-1:0]  rate_raw_r [3];
  logic signed [RAW_W-1:0]  rate_raw_nxt [3];
  logic signed [ACC_W-1:0]  acc_s_r [3];
  logic signed [ACC_W-1:0]  acc_s_nxt [3];
  logic signed [RATE_W-1:0] rate_s_r [3];
  logic signed [RATE_W-1:0] rate_s_nxt [3];
  logic signed [ANG_W-1:0]  ang_r [2];
  logic signed [ANG_W-1:0]  ang_nxt [2];
  logic signed [SUM_W-1:0]  sum_r [3];
  logic signed [SUM_W-1:0]  sum_nxt [3];
  logic signed [BIAS_W-1:0] bias_r [3];
  logic signed [BIAS_W-1:0] bias_nxt [3];
  logic                     seeded_r, seeded_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     upd_r, upd_nxt;
  logic signed [RATE_W+1:0] rdiv_r, rdiv_nxt;
  logic signed [CW-1:0]     mag_r, mag_nxt;
  logic signed [ANG_W-1:0]  accang_r, accang_nxt;
  logic signed [ANG_W+1:0]  g_r, g_nxt;

  logic [COEF_W-1:0] acc_coef_r, gyro_coef_r;
  logic [WGT_W-1:0]  pitch_w_r, roll_w_r;
  logic [DT_W-1:0]   dt_r;

  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0] out_data_r, out_data_nxt;
  logic              out_user_r, out_user_nxt;

  // shared units
  logic                     mul_start, mul_done;
  logic signed [MUL_AW-1:0] mul_a;
  logic        [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] mul_p;
  logic                     div_start, div_done;
  logic [DIV_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic [DIV_W-1:0]         div_q;
  logic                     cor_start, cor_done;
  logic signed [CW-1:0]     cor_x, cor_y, cor_xo;
  logic signed [ZW-1:0]     cor_zo;
  logic                     mul_wait, div_wait;

  // working values
  logic signed [CW-1:0]     ax, ay, az, az_abs, num_v, p_v;
  logic signed [DW-1:0]     gd;
  logic signed [D5-1:0]     gd5;
  logic [D5-1:0]            gd5_abs;
  logic [SUM_W-1:0]         sum_abs;
  logic signed [MUL_PW-1:0] wide_v, res_v;
  logic signed [DIV_W-1:0]  q_neg;
  logic signed [ANG_W-1:0]  base_ang;
  logic [WGT_W-1:0]         wsel;
  logic signed [MUL_PW-1:0] trim_v;

  // accelerometer terms at the CORDIC scale
  assign ax     = CW'(acc_s_r[0]) <<< PRE_SH;
  assign ay     = CW'(acc_s_r[1]) <<< PRE_SH;
  assign az     = CW'(acc_s_r[2]) <<< PRE_SH;
  assign az_abs = az[CW-1] ? -az : az;
  assign num_v  = j_r ? ay : ax;
  assign p_v    = j_r ? ax : ay;

  // bias-corrected gyro numerator for the current axis
  assign gd      = (DW'(rate_raw_r[k_r]) <<< Q16_SH) - DW'(bias_r[k_r]);
  assign gd5     = (D5'(gd) <<< 2) + D5'(gd);
  assign gd5_abs = gd5[D5-1] ? D5'(-gd5) : D5'(gd5);
  assign sum_abs = sum_r[k_r][SUM_W-1] ? SUM_W'(-sum_r[k_r]) : SUM_W'(sum_r[k_r]);
  assign q_neg   = -$signed(div_q);

  assign base_ang = seeded_r ? ang_r[j_r] : accang_r;
  assign wsel     = j_r ? roll_w_r : pitch_w_r;
  assign trim_v   = MUL_PW'(rate_s_r[2]) + MUL_PW'(Z_TRIM);

  // unit operands
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    cor_start = 1'b0;
    cor_x     = '0;
    cor_y     = '0;
    unique case (state_r)
      ST_AMUL_GO: begin
        mul_start = 1'b1;
        mul_a     = (MUL_AW'(acc_raw_r[k_r]) <<< 4) - MUL_AW'(acc_s_r[k_r]);
        mul_b     = MUL_BW'(acc_coef_r);
      end
      ST_GMUL_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_AW'(rdiv_r) - MUL_AW'(rate_s_r[k_r]);
        mul_b     = MUL_BW'(gyro_coef_r);
      end
      ST_MAG_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_AW'(cor_xo);
        mul_b     = MUL_BW'(INV_GAIN);
      end
      ST_DT_GO: begin
        mul_start = 1'b1;
        mul_a     = j_r ? MUL_AW'(rate_s_r[0]) : MUL_AW'(rate_s_r[1]);
        mul_b     = MUL_BW'(dt_r);
      end
      ST_W_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_AW'(g_r) - MUL_AW'(accang_r);
        mul_b     = (wsel > WGT_W'(WGT_ONE)) ? WGT_W'(WGT_ONE) : wsel;
      end
      ST_BDIV_GO: begin
        div_start = 1'b1;
        div_num   = (DIV_W'(sum_abs) << Q16_SH) + DIV_W'(CAL_SAMPLES / 2);
        div_den   = DEN_W'(CAL_SAMPLES);
      end
      ST_GDIV_GO: begin
        div_start = 1'b1;
        div_num   = DIV_W'(gd5_abs) + DIV_W'(RATE_HALF);
        div_den   = DEN_W'(RATE_DEN);
      end
      ST_COR1_GO: begin
        cor_start = (p_v != '0);
        cor_x     = az_abs;
        cor_y     = p_v;
      end
      ST_COR2_GO: begin
        cor_start = (num_v != '0);
        cor_x     = mag_r;
        cor_y     = num_v;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    acc_raw_nxt   = acc_raw_r;
    rate_raw_nxt  = rate_raw_r;
    acc_s_nxt     = acc_s_r;
    rate_s_nxt    = rate_s_r;
    ang_nxt       = ang_r;
    sum_nxt       = sum_r;
    bias_nxt      = bias_r;
    seeded_nxt    = seeded_r;
    cnt_nxt       = cnt_r;
    upd_nxt       = upd_r;
    rdiv_nxt      = rdiv_r;
    mag_nxt       = mag_r;
    accang_nxt    = accang_r;
    g_nxt         = g_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    wide_v        = '0;
    res_v         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          for (int a = 0; a < 3; a++) begin
            acc_raw_nxt[a]  = in_tdata[a*RAW_W +: RAW_W];
            rate_raw_nxt[a] = in_tdata[(a+3)*RAW_W +: RAW_W];
          end
          upd_nxt   = 1'b0;
          k_nxt     = '0;
          state_nxt = in_tuser ? ST_CAL : ST_AMUL_GO;
        end
      end
      ST_CAL: begin
        for (int a = 0; a < 3; a++) begin
          sum_nxt[a] = sum_r[a] + SUM_W'(rate_raw_r[a]);
        end
        if (cnt_r + CNT_W'(1) >= CNT_W'(CAL_SAMPLES)) begin
          cnt_nxt   = '0;
          upd_nxt   = 1'b1;
          state_nxt = ST_BDIV_GO;
        end else begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = ST_DONE;
        end
      end
      ST_BDIV_GO: state_nxt = ST_BDIV_WT;
      ST_BDIV_WT: begin
        if (div_done) begin
          bias_nxt[k_r] = sum_r[k_r][SUM_W-1] ? BIAS_W'(q_neg) : BIAS_W'(div_q);
          sum_nxt[k_r]  = '0;
          if (k_r == 2'd2) begin
            state_nxt = ST_DONE;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ST_BDIV_GO;
          end
        end
      end
      ST_AMUL_GO: state_nxt = ST_AMUL_WT;
      ST_AMUL_WT: begin
        if (mul_done) begin
          wide_v           = MUL_PW'(acc_s_r[k_r]) + rnd_shift(mul_p, Q16_SH);
          res_v            = clamp(wide_v, MUL_PW'(-ACC_LIM), MUL_PW'(ACC_LIM));
          acc_s_nxt[k_r]   = res_v[ACC_W-1:0];
          if (k_r == 2'd2) begin
            k_nxt     = '0;
            state_nxt = ST_GDIV_GO;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ST_AMUL_GO;
          end
        end
      end
      ST_GDIV_GO: state_nxt = ST_GDIV_WT;
      ST_GDIV_WT: begin
        if (div_done) begin
          rdiv_nxt  = gd5[D5-1] ? (RATE_W+2)'(q_neg) : (RATE_W+2)'(div_q);
          state_nxt = ST_GMUL_GO;
        end
      end
      ST_GMUL_GO: state_nxt = ST_GMUL_WT;
      ST_GMUL_WT: begin
        if (mul_done) begin
          wide_v          = MUL_PW'(rate_s_r[k_r]) + rnd_shift(mul_p, Q16_SH);
          res_v           = clamp(wide_v, MUL_PW'(RATE_LO), MUL_PW'(RATE_HI));
          rate_s_nxt[k_r] = res_v[RATE_W-1:0];
          if (k_r == 2'd2) begin
            k_nxt     = '0;
            j_nxt     = 1'b0;
            state_nxt = ST_COR1_GO;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ST_GDIV_GO;
          end
        end
      end
      // magnitude of the two other axes; a zero operand skips the rotation
      ST_COR1_GO: begin
        if (p_v == '0) begin
          mag_nxt   = az_abs;
          state_nxt = ST_COR2_GO;
        end else begin
          state_nxt = ST_COR1_WT;
        end
      end
      ST_COR1_WT: begin
        if (cor_done) state_nxt = ST_MAG_GO;
      end
      ST_MAG_GO: state_nxt = ST_MAG_WT;
      ST_MAG_WT: begin
        if (mul_done) begin
          res_v     = rnd_shift(mul_p, Q16_SH);
          mag_nxt   = res_v[CW-1:0];
          state_nxt = ST_COR2_GO;
        end
      end
      // accelerometer angle
      ST_COR2_GO: begin
        if (num_v == '0) begin
          accang_nxt = '0;
          state_nxt  = ST_DT_GO;
        end else begin
          state_nxt = ST_COR2_WT;
        end
      end
      ST_COR2_WT: begin
        if (cor_done) begin
          accang_nxt = -cor_zo;
          state_nxt  = ST_DT_GO;
        end
      end
      ST_DT_GO: state_nxt = ST_DT_WT;
      ST_DT_WT: begin
        if (mul_done) begin
          wide_v    = MUL_PW'(base_ang) + rnd_shift(mul_p, DT_SH);
          g_nxt     = wide_v[ANG_W+1:0];
          state_nxt = ST_W_GO;
        end
      end
      ST_W_GO: state_nxt = ST_W_WT;
      // blend: acc + (gyro - acc) * w, in Q16
      ST_W_WT: begin
        if (mul_done) begin
          wide_v       = mul_p + (MUL_PW'(accang_r) <<< Q16_SH);
          res_v        = clamp(rnd_shift(wide_v, Q16_SH), MUL_PW'(-ANGLE_LIM),
                               MUL_PW'(ANGLE_LIM));
          ang_nxt[j_r] = res_v[ANG_W-1:0];
          if (j_r) begin
            seeded_nxt = 1'b1;
            state_nxt  = ST_DONE;
          end else begin
            j_nxt     = 1'b1;
            state_nxt = ST_COR1_GO;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          res_v         = clamp(trim_v, MUL_PW'(RATE_LO), MUL_PW'(RATE_HI));
          out_valid_nxt = 1'b1;
          out_user_nxt  = upd_r;
          out_data_nxt  = {ang_r[1], ang_r[0], res_v[RATE_W-1:0], rate_s_r[1], rate_s_r[0],
                           acc_s_r[2], acc_s_r[1], acc_s_r[0]};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      j_r         <= 1'b0;
      seeded_r    <= 1'b0;
      cnt_r       <= '0;
      upd_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        acc_s_r[a]  <= '0;
        rate_s_r[a] <= '0;
        sum_r[a]    <= '0;
        bias_r[a]   <= '0;
      end
      ang_r[0] <= '0;
      ang_r[1] <= '0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      seeded_r    <= seeded_nxt;
      cnt_r       <= cnt_nxt;
      upd_r       <= upd_nxt;
      out_valid_r <= out_valid_nxt;
      acc_s_r     <= acc_s_nxt;
      rate_s_r    <= rate_s_nxt;
      sum_r       <= sum_nxt;
      bias_r      <= bias_nxt;
      ang_r       <= ang_nxt;
    end
    acc_raw_r  <= acc_raw_nxt;
    rate_raw_r <= rate_raw_nxt;
    rdiv_r     <= rdiv_nxt;
    mag_r      <= mag_nxt;
    accang_r   <= accang_nxt;
    g_r        <= g_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_coef_r  <= COEF_W'(ACC_COEF_RST);
      gyro_coef_r <= COEF_W'(GYRO_COEF_RST);
      pitch_w_r   <= WGT_W'(PITCH_W_RST);
      roll_w_r    <= WGT_W'(ROLL_W_RST);
      dt_r        <= DT_W'(DT_RST);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_ACC_SMOOTH:  acc_coef_r  <= cfg_wdata[COEF_W-1:0];
        CFG_GYRO_SMOOTH: gyro_coef_r <= cfg_wdata[COEF_W-1:0];
        CFG_PITCH_W:     pitch_w_r   <= cfg_wdata[WGT_W-1:0];
        CFG_ROLL_W:      roll_w_r    <= cfg_wdata[WGT_W-1:0];
        CFG_DT:          dt_r        <= cfg_wdata[DT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ict_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  ict_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  ict_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .x0    (cor_x),
    .y0    (cor_y),
    .done  (cor_done),
    .xo    (cor_xo),
    .zo    (cor_zo)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // states that wait on the shared multiplier and divider
  assign mul_wait = (state_r == ST_AMUL_WT) || (state_r == ST_GMUL_WT) ||
                    (state_r == ST_MAG_WT) || (state_r == ST_DT_WT) || (state_r == ST_W_WT);
  assign div_wait = (state_r == ST_BDIV_WT) || (state_r == ST_GDIV_WT);

  // a taken request starts the sequencer
  `ICT_ASSERT_NXT(a_busy_after_req, in_tvalid && in_tready, !in_tready)
  // multiplier results land only where the sequencer waits for them
  `ICT_ASSERT_IMP(a_mul_done_wait, mul_done, mul_wait)
  // divider results land only where the sequencer waits for them
  `ICT_ASSERT_IMP(a_div_done_wait, div_done, div_wait)
  // calibration counter wraps before the sample count
  `ICT_ASSERT_IMP(a_cal_count, 1'b1, cnt_r < CNT_W'(CAL_SAMPLES))

endmodule

>>> sim/imu_tilt_complementary_filter_test.sv
// Self-checking testbench for the IMU tilt filter: calibration, smoothing, CORDIC tilt, fusion.
module imu_tilt_complementary_filter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ict_pkg::*;

  localparam logic CMD_PROCESS   = 1'b0;
  localparam logic CMD_CALIBRATE = 1'b1;
  localparam int   SETTLE_CYCLES = 600;

  typedef struct {
    logic signed [ACC_W-1:0]  acc [3];
    logic signed [RATE_W-1:0] rate [3];
    logic signed [ANG_W-1:0]  pitch;
    logic signed [ANG_W-1:0]  roll;
    logic                     bias_new;
  } tilt_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DW-1:0]     in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_DW-1:0]    out_tdata;
  logic                 out_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_AW-1:0]    cfg_addr = '0;
  logic [CFG_DW-1:0]    cfg_wdata = '0;

  imu_tilt_complementary_filter dut (.*);

  always #6 clk = ~clk;

  // predictor state and register copies
  longint smooth_q16 [6];
  longint angle_q16 [2];
  bit     seeded;
  longint gyro_sums [3];
  int     cal_count;
  longint bias_q16 [3];
  longint acc_coef, gyro_coef, pitch_wgt, roll_wgt, step_q24;

  tilt_result_t expected_results [$];
  int errors = 0;
  int sent_total = 0, cal_total = 0, bias_total = 0, checked_total = 0;

  // sender burst shaping and receiver stall control
  int burst_left = 0;
  int gap_max = 4, burst_max = 8;
  int stall_pct = 30;
  int hold_len = 0;

  function automatic longint rnd_shr(longint v, int sh);
    longint half;
    half = longint'(1) << (sh - 1);
    return v >= 0 ? (v + half) >>> sh : -((-v + half) >>> sh);
  endfunction

  function automatic longint div_rnd(longint num, longint den);
    longint q;
    q = ((num < 0 ? -num : num) + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // vectoring CORDIC with x >= 0: angle in degrees Q16, gain-corrected magnitude
  function automatic longint cordic_atan(longint x, longint y, output longint mag);
    longint z, xs, ys;
    z = 0;
    if (y == 0) begin
      mag = x;
      return 0;
    end
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(atan_q16(5'(i)));
      end else begin
        x -= ys; y += xs; z -= longint'(atan_q16(5'(i)));
      end
    end
    mag = rnd_shr(x * INV_GAIN, Q16_SH);
    return z;
  endfunction

  function automatic longint tilt_angle(longint num, longint p, longint q);
    longint r, unused;
    void'(cordic_atan(q < 0 ? -q : q, p, r));
    return -cordic_atan(r, num, unused);
  endfunction

  function automatic longint fuse_angle(longint ang, longint rate, longint acc, longint wreg);
    longint w, g;
    w = wreg > WGT_ONE ? WGT_ONE : wreg;
    g = ang + rnd_shr(rate * step_q24, DT_SH);
    g = rnd_shr(g * w + acc * (WGT_ONE - w), Q16_SH);
    return clip(g, -ANGLE_LIM, ANGLE_LIM);
  endfunction

  // advance the filter model by one accepted request
  function automatic tilt_result_t predict_tilt(logic cmd, logic signed [RAW_W-1:0] raw [6]);
    tilt_result_t res;
    longint s, d, pa, ra;
    res.bias_new = 1'b0;
    if (cmd == CMD_CALIBRATE) begin
      for (int k = 0; k < 3; k++) gyro_sums[k] += longint'(raw[3+k]);
      cal_count++;
      if (cal_count >= CAL_SAMPLES) begin
        for (int k = 0; k < 3; k++) begin
          bias_q16[k] = div_rnd(gyro_sums[k] * 65536, CAL_SAMPLES);
          gyro_sums[k] = 0;
        end
        cal_count = 0;
        res.bias_new = 1'b1;
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        s = smooth_q16[k];
        s += rnd_shr((longint'(raw[k]) * 16 - s) * acc_coef, Q16_SH);
        smooth_q16[k] = clip(s, -ACC_LIM, ACC_LIM);
      end
      for (int k = 0; k < 3; k++) begin
        d = longint'(raw[3+k]) * 65536 - bias_q16[k];
        s = smooth_q16[3+k];
        s += rnd_shr((div_rnd(d * 5, RATE_DEN) - s) * gyro_coef, Q16_SH);
        smooth_q16[3+k] = clip(s, RATE_LO, RATE_HI);
      end
      pa = tilt_angle(smooth_q16[0] << PRE_SH, smooth_q16[1] << PRE_SH, smooth_q16[2] << PRE_SH);
      ra = tilt_angle(smooth_q16[1] << PRE_SH, smooth_q16[0] << PRE_SH, smooth_q16[2] << PRE_SH);
      if (!seeded) begin
        seeded = 1'b1;
        angle_q16[0] = pa;
        angle_q16[1] = ra;
      end
      angle_q16[0] = fuse_angle(angle_q16[0], smooth_q16[4], pa, pitch_wgt);
      angle_q16[1] = fuse_angle(angle_q16[1], smooth_q16[3], ra, roll_wgt);
    end
    for (int k = 0; k < 3; k++) res.acc[k] = ACC_W'(smooth_q16[k]);
    res.rate[0] = RATE_W'(smooth_q16[3]);
    res.rate[1] = RATE_W'(smooth_q16[4]);
    res.rate[2] = RATE_W'(clip(smooth_q16[5] + Z_TRIM, RATE_LO, RATE_HI));
    res.pitch = ANG_W'(angle_q16[0]);
    res.roll  = ANG_W'(angle_q16[1]);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= 30)
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    tilt_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      for (int k = 0; k < 3; k++) begin
        got.acc[k]  = out_tdata[k*ACC_W +: ACC_W];
        got.rate[k] = out_tdata[3*ACC_W + k*RATE_W +: RATE_W];
      end
      got.pitch    = out_tdata[3*ACC_W + 3*RATE_W +: ANG_W];
      got.roll     = out_tdata[3*ACC_W + 3*RATE_W + ANG_W +: ANG_W];
      got.bias_new = out_tuser;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_results.pop_front();
        checked_total++;
        for (int k = 0; k < 3; k++) begin
          if (got.acc[k] !== want.acc[k])
            report_mismatch($sformatf("accel[%0d]", k), got.acc[k], want.acc[k]);
          if (got.rate[k] !== want.rate[k])
            report_mismatch($sformatf("rate[%0d]", k), got.rate[k], want.rate[k]);
        end
        if (got.pitch !== want.pitch) report_mismatch("pitch", got.pitch, want.pitch);
        if (got.roll !== want.roll) report_mismatch("roll", got.roll, want.roll);
        if (got.bias_new !== want.bias_new)
          report_mismatch("bias_updated", got.bias_new, want.bias_new);
      end
    end
  end

  // receiver: long hold-off on request, else a random stall pattern
  always @(posedge clk) begin
    if (hold_len > 0) begin
      out_tready <= 1'b0;
      hold_len = hold_len - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // offer one request, with bursts and random gaps; predict on acceptance
  task automatic send_request(logic cmd, logic signed [RAW_W-1:0] raw [6]);
    logic [IN_DW-1:0] data;
    if (burst_left == 0) begin
      repeat ($urandom_range(0, gap_max)) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    for (int k = 0; k < 6; k++) data[k*RAW_W +: RAW_W] = raw[k];
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_tilt(cmd, raw));
    sent_total++;
    if (cmd == CMD_CALIBRATE) cal_total++;
    burst_left--;
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  function automatic logic signed [RAW_W-1:0] rand_raw(int span);
    case ($urandom_range(0, 9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return '0;
      3, 4, 5: return RAW_W'($urandom_range(0, 2 * span) - span);
      default: return RAW_W'($urandom);
    endcase
  endfunction

  task automatic send_random(logic cmd);
    logic signed [RAW_W-1:0] raw [6];
    for (int k = 0; k < 3; k++) raw[k] = rand_raw(9000);
    for (int k = 3; k < 6; k++) raw[k] = rand_raw(2000);
    send_request(cmd, raw);
  endtask

  task automatic send_axes(logic cmd, int ax, int ay, int az, int gx, int gy, int gz);
    logic signed [RAW_W-1:0] raw [6];
    raw = '{RAW_W'(ax), RAW_W'(ay), RAW_W'(az), RAW_W'(gx), RAW_W'(gy), RAW_W'(gz)};
    send_request(cmd, raw);
  endtask

  // wait until every result is back and the sequencer has gone quiet
  task automatic drain_results();
    stop_sending();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_registers(int ac, int gc, int pw, int rw, int dt);
    cfg_reg_t idx [5];
    int vals [5];
    idx  = '{CFG_ACC_SMOOTH, CFG_GYRO_SMOOTH, CFG_PITCH_W, CFG_ROLL_W, CFG_DT};
    vals = '{ac, gc, pw, rw, dt};
    drain_results();
    for (int k = 0; k < 5; k++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[k];
      cfg_wdata <= CFG_DW'(vals[k]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    acc_coef  = ac & 16'hFFFF;
    gyro_coef = gc & 16'hFFFF;
    pitch_wgt = pw & 17'h1FFFF;
    roll_wgt  = rw & 17'h1FFFF;
    step_q24  = dt & 16'hFFFF;
  endtask

  // extremes, seeding on the first process request, zero-numerator tilt
  task automatic test_directed();
    send_axes(CMD_PROCESS, 0, 0, 4096, 0, 0, 0);
    send_axes(CMD_PROCESS, 0, 0, 0, 0, 0, 0);
    send_axes(CMD_PROCESS, 32767, 32767, 32767, 32767, 32767, 32767);
    send_axes(CMD_PROCESS, -32768, -32768, -32768, -32768, -32768, -32768);
    send_axes(CMD_PROCESS, 0, 4096, 0, 100, -100, 50);
    send_axes(CMD_PROCESS, 4096, 0, -4096, -5, 5, 0);
    send_axes(CMD_PROCESS, -4096, 0, 0, 0, 0, 0);
    send_axes(CMD_PROCESS, 0, -4096, -100, 0, 0, 0);
    send_axes(CMD_CALIBRATE, 1, 2, 3, 32767, -32768, 7);
    send_axes(CMD_CALIBRATE, -1, -2, -3, -32768, 32767, -7);
    send_axes(CMD_PROCESS, 1, -1, 4095, 1, -1, 0);
    send_axes(CMD_PROCESS, -21846, 21845, 12345, -333, 444, -555);
  endtask

  // full calibration runs with random content, then use of the new bias
  task automatic test_calibration(int runs);
    for (int r = 0; r < runs; r++) begin
      for (int i = 0; i < CAL_SAMPLES; i++) send_random(CMD_CALIBRATE);
      repeat (6) send_random(CMD_PROCESS);
    end
  endtask

  // register settings, extremes included, each with a block of random traffic
  task automatic test_registers();
    int settings [6][5];
    settings = '{
      '{0, 0, 0, 0, 0},
      '{65535, 65535, 65536, 65536, 65535},
      '{65535, 65535, 131071, 100000, 1},
      '{32768, 1, 1, 65535, 40000},
      '{1, 32768, 32768, 0, 8389},
      '{ACC_COEF_RST, GYRO_COEF_RST, PITCH_W_RST, ROLL_W_RST, DT_RST}};
    foreach (settings[p]) begin
      write_registers(settings[p][0], settings[p][1], settings[p][2],
                      settings[p][3], settings[p][4]);
      for (int i = 0; i < 70; i++)
        send_random($urandom_range(0, 9) == 0 ? CMD_CALIBRATE : CMD_PROCESS);
    end
  endtask

  // receiver holds off while the sender keeps offering, then a full pause
  task automatic test_backpressure();
    gap_max = 0;
    burst_max = 50;
    hold_len = 3000;
    for (int i = 0; i < 20; i++) send_random($urandom_range(0, 1));
    drain_results();
    gap_max = 4;
    burst_max = 8;
  endtask

  // random traffic under changing idle patterns, with occasional calibration runs
  task automatic test_random(int count);
    int phase_left;
    phase_left = 0;
    for (int i = 0; i < count; i++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(50, 200);
        stall_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 80);
        gap_max   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      end
      phase_left--;
      if ($urandom_range(0, 299) == 0) begin
        for (int j = 0; j < CAL_SAMPLES; j++) send_random(CMD_CALIBRATE);
        i += CAL_SAMPLES;
      end else begin
        send_random($urandom_range(0, 19) == 0 ? CMD_CALIBRATE : CMD_PROCESS);
      end
    end
  endtask

  initial begin
    foreach (smooth_q16[k]) smooth_q16[k] = 0;
    foreach (gyro_sums[k]) begin
      gyro_sums[k] = 0;
      bias_q16[k] = 0;
    end
    angle_q16 = '{0, 0};
    seeded = 1'b0;
    cal_count = 0;
    acc_coef  = ACC_COEF_RST;
    gyro_coef = GYRO_COEF_RST;
    pitch_wgt = PITCH_W_RST;
    roll_wgt  = ROLL_W_RST;
    step_q24  = DT_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_calibration(2);
    test_backpressure();
    test_registers();
    test_random(1130);
    drain_results();

    foreach (expected_results[k]) report_mismatch("missing result", 0, 1);
    $display("Covered %0d requests (%0d calibration, %0d bias updates), %0d results checked,",
             sent_total, cal_total, bias_total, checked_total);
    $display("six register settings, a long output hold-off and full drains.");
    if (errors == 0)
      $display("imu_tilt_complementary_filter test passed");
    else
      $display("imu_tilt_complementary_filter test failed");
    $finish;
  end

  // bias completions, counted for the summary only
  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready && out_tuser) bias_total++;

  // run limit
  initial begin
    #60_000_000;
    $display("imu_tilt_complementary_filter test failed");
    $finish;
  end

endmodule
